[rtl/core/ubx_ack_receiver_macros.svh]
// Assertion macros shared by the acknowledge receiver RTL.
`ifndef UBX_ACK_RECEIVER_MACROS_SVH
`define UBX_ACK_RECEIVER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define UBXACK_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define UBXACK_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/core/ubxack_pkg.sv]
// Shared types, codes and constants of the acknowledge receiver.
`timescale 1ns / 1ps

package ubxack_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned CAP_DEPTH = 7;
   localparam int unsigned CAP_IDX_W = 3;

   localparam logic [POS_W-1:0] HDR_LEN   = 4'd3;
   localparam logic [POS_W-1:0] FRAME_LEN = 4'd10;
   localparam logic [POS_W-1:0] NAK_POS   = 4'd4;

   localparam logic [BYTE_W-1:0] HDR_SYNC1 = 8'hB5;
   localparam logic [BYTE_W-1:0] HDR_SYNC2 = 8'h62;
   localparam logic [BYTE_W-1:0] HDR_CLASS = 8'h05;
   localparam logic [BYTE_W-1:0] NAK_ID    = 8'h00;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1500;
   localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

   // Request operation codes.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Verdict codes.
   localparam logic [1:0] VERDICT_ACK     = 2'd0;
   localparam logic [1:0] VERDICT_REJECT  = 2'd1;
   localparam logic [1:0] VERDICT_TIMEOUT = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_EXP_CLASS  = 2'd0;
   localparam logic [1:0] CSR_EXP_MSG_ID = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   // Frame bytes 3 to 9, entry 0 holds frame byte 3.
   typedef logic [CAP_DEPTH-1:0][BYTE_W-1:0] cap_type;

   function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] pos);
      logic [BYTE_W-1:0] val;
      begin
         case (pos)
            2'd0:    val = HDR_SYNC1;
            2'd1:    val = HDR_SYNC2;
            default: val = HDR_CLASS;
         endcase
         return val;
      end
   endfunction

endpackage

[rtl/core/ubxack_judge.sv]
// Fletcher checksum and acknowledged class/id check of a complete frame.
`timescale 1ns / 1ps

module ubxack_judge
   import ubxack_pkg::*;
(
   input  cap_type           cap,
   input  logic [BYTE_W-1:0] expected_class,
   input  logic [BYTE_W-1:0] expected_msg_id,
   output logic              frame_ok
);

   logic [BYTE_W-1:0] ck_a;
   logic [BYTE_W-1:0] ck_b;

   // The class byte of the header starts the sum; five captured bytes follow it.
   always_comb begin
      ck_a = HDR_CLASS;
      ck_b = HDR_CLASS;
      for (int k = 0; k < 5; k++) begin
         ck_a = ck_a + cap[k];
         ck_b = ck_b + ck_a;
      end
   end

   assign frame_ok = (cap[3] == expected_class) && (cap[4] == expected_msg_id) &&
                     (cap[5] == ck_a) && (cap[6] == ck_b);

endmodule

[rtl/core/ubx_ack_receiver.sv]
// Acknowledge receiver: one registered processing stage and a result register.
// A request is held in the input register, and its verdict is then registered in the result register on rsp_verdict.
// Throughput: one request per cycle while no result is held; the frame state updates in a single stage.
// A held result stalls the processing stage, and the input register then stalls req.
// Reset (synchronous, active high) idles the receiver and restores the register defaults.
`timescale 1ns / 1ps

`include "ubx_ack_receiver_macros.svh"

module ubx_ack_receiver
   import ubxack_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_verdict,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [TICK_W-1:0] csr_data
);

   logic [BYTE_W-1:0] exp_class_ff;
   logic [BYTE_W-1:0] exp_msg_id_ff;
   logic [TICK_W-1:0] timeout_ff;

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_op_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   logic              waiting_ff, waiting_in;
   logic [POS_W-1:0]  frame_pos_ff, frame_pos_in;
   cap_type           cap_ff, cap_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_verdict_ff, rsp_verdict_in;

   logic              advance;
   logic              proc;
   logic              req_accept;
   logic              out_load;
   logic              frame_ok;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign proc       = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   ubxack_judge u_judge (
      .cap             (cap_in),
      .expected_class  (exp_class_ff),
      .expected_msg_id (exp_msg_id_ff),
      .frame_ok        (frame_ok)
   );

   always_comb begin
      waiting_in     = waiting_ff;
      frame_pos_in   = frame_pos_ff;
      cap_in         = cap_ff;
      elapsed_in     = elapsed_ff;
      out_load       = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      if (proc) begin
         case (in_op_ff)
            OP_START: begin
               waiting_in   = 1'b1;
               frame_pos_in = '0;
               elapsed_in   = '0;
            end
            OP_BYTE: begin
               if (waiting_ff) begin
                  // A header byte that does not match is dropped without a restart.
                  if (frame_pos_ff < HDR_LEN) begin
                     if (in_byte_ff == hdr_byte(frame_pos_ff[1:0])) begin
                        frame_pos_in = frame_pos_ff + 4'd1;
                     end
                  end else if (frame_pos_ff < FRAME_LEN) begin
                     cap_in[CAP_IDX_W'(frame_pos_ff - HDR_LEN)] = in_byte_ff;
                     frame_pos_in = frame_pos_ff + 4'd1;
                  end
                  if (frame_pos_in >= FRAME_LEN) begin
                     waiting_in     = 1'b0;
                     out_load       = 1'b1;
                     rsp_verdict_in = frame_ok ? VERDICT_ACK : VERDICT_REJECT;
                  end else if (frame_pos_in == NAK_POS && cap_in[0] == NAK_ID) begin
                     waiting_in     = 1'b0;
                     out_load       = 1'b1;
                     rsp_verdict_in = VERDICT_REJECT;
                  end
               end
            end
            OP_TICK: begin
               if (waiting_ff) begin
                  if (elapsed_ff != TICK_MAX) begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
                  if (elapsed_in > timeout_ff) begin
                     waiting_in     = 1'b0;
                     out_load       = 1'b1;
                     rsp_verdict_in = VERDICT_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_class_ff  <= '0;
         exp_msg_id_ff <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         in_valid_ff   <= 1'b0;
         waiting_ff    <= 1'b0;
         frame_pos_ff  <= '0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_EXP_CLASS:  exp_class_ff  <= csr_data[BYTE_W-1:0];
               CSR_EXP_MSG_ID: exp_msg_id_ff <= csr_data[BYTE_W-1:0];
               CSR_TIMEOUT:    timeout_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         in_valid_ff  <= in_valid_in;
         waiting_ff   <= waiting_in;
         frame_pos_ff <= frame_pos_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_rx_byte;
      end
      cap_ff         <= cap_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // A request held in the input register is never dropped while the output is blocked.
   `UBXACK_ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, in_valid_ff, "input request lost")
   // Once the frame is complete the receiver must have stopped waiting.
   `UBXACK_ASSERT_ALWAYS(a_pos_bound, !(waiting_ff && frame_pos_ff >= FRAME_LEN), "frame overrun")
   // Every newly loaded verdict ends the wait in the same update.
   `UBXACK_ASSERT_NEXT(a_verdict_ends, out_load, rsp_valid_ff && !waiting_ff, "verdict while waiting")

endmodule

[bench/tb_ubx_ack_receiver.sv]
// Self-checking testbench for the UBX acknowledge receiver with a verdict scoreboard.
`timescale 1ns / 1ps

module tb_ubx_ack_receiver;
   import ubxack_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         ITEMS_PER_PHASE = 160;
   localparam int         DRAIN_CYCLES    = 8;

   // Tracks the receiver state and holds the verdicts still owed by the block.
   class ack_scoreboard;
      logic [BYTE_W-1:0] exp_class;
      logic [BYTE_W-1:0] exp_msg_id;
      logic [TICK_W-1:0] tick_limit;
      bit                listening;
      logic [POS_W-1:0]  pos;
      cap_type           tail;
      logic [TICK_W-1:0] elapsed;
      logic [1:0]        verdicts[$];
      int                errors;

      function new();
         exp_class  = '0;
         exp_msg_id = '0;
         tick_limit = TIMEOUT_RESET;
         listening  = 0;
         pos        = '0;
         tail       = '0;
         elapsed    = '0;
         errors     = 0;
      endfunction

      // Fletcher sum over the class byte and frame bytes 3 to 7; {ck_a, ck_b}.
      function logic [15:0] frame_sum(logic [4:0][BYTE_W-1:0] body);
         logic [BYTE_W-1:0] ck_a;
         logic [BYTE_W-1:0] ck_b;
         ck_a = HDR_CLASS;
         ck_b = ck_a;
         for (int k = 0; k < 5; k++) begin
            ck_a = ck_a + body[k];
            ck_b = ck_b + ck_a;
         end
         return {ck_a, ck_b};
      endfunction

      function void write_reg(logic [1:0] idx, logic [TICK_W-1:0] data);
         case (idx)
            CSR_EXP_CLASS:  exp_class  = data[BYTE_W-1:0];
            CSR_EXP_MSG_ID: exp_msg_id = data[BYTE_W-1:0];
            CSR_TIMEOUT:    tick_limit = data;
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] op, logic [BYTE_W-1:0] b);
         logic [BYTE_W-1:0] want;
         logic [15:0]       sum;
         case (op)
            OP_START: begin
               listening = 1;
               pos       = '0;
               elapsed   = '0;
            end
            OP_TICK: begin
               if (listening) begin
                  if (elapsed != TICK_MAX) elapsed = elapsed + 1'b1;
                  if (elapsed > tick_limit) begin
                     listening = 0;
                     verdicts.push_back(VERDICT_TIMEOUT);
                  end
               end
            end
            OP_BYTE: begin
               if (listening) begin
                  if (pos < HDR_LEN) begin
                     want = (pos == 0) ? HDR_SYNC1 : (pos == 1) ? HDR_SYNC2 : HDR_CLASS;
                     // A wrong header byte is dropped without losing the position.
                     if (b == want) pos = pos + 1'b1;
                  end else if (pos < FRAME_LEN) begin
                     tail[CAP_IDX_W'(pos - HDR_LEN)] = b;
                     pos = pos + 1'b1;
                  end
                  if (pos == FRAME_LEN) begin
                     listening = 0;
                     sum = frame_sum(tail[4:0]);
                     if (tail[3] == exp_class && tail[4] == exp_msg_id &&
                         tail[5] == sum[15:8] && tail[6] == sum[7:0])
                        verdicts.push_back(VERDICT_ACK);
                     else
                        verdicts.push_back(VERDICT_REJECT);
                  end else if (pos == NAK_POS && tail[0] == NAK_ID) begin
                     listening = 0;
                     verdicts.push_back(VERDICT_REJECT);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_verdict(logic [1:0] got);
         logic [1:0] want;
         if (verdicts.size() == 0) begin
            report($sformatf("verdict %0d with none expected", got));
         end else begin
            want = verdicts.pop_front();
            if (got !== want)
               report($sformatf("verdict %0d, expected %0d", got, want));
         end
      endtask

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic [1:0]        req_op      = OP_START;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic [1:0]        rsp_verdict;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index   = CSR_EXP_CLASS;
   logic [TICK_W-1:0] csr_data    = '0;

   ack_scoreboard sb = new();
   bit            req_gaps = 1;
   bit            rsp_gaps = 1;
   int            n_sent   = 0;

   ubx_ack_receiver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_op, req_rx_byte);
         if (rsp_valid && !rsp_stall) sb.check_verdict(rsp_verdict);
      end
   end

   // Result side back-pressure in bursts.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_gaps && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task send_request(logic [1:0] op, logic [BYTE_W-1:0] b);
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_rx_byte <= b;
      n_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task maybe_tick();
      if ($urandom_range(0, 11) == 0) send_request(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   task send_header();
      logic [BYTE_W-1:0] want;
      logic [BYTE_W-1:0] junk;
      for (int p = 0; p < 3; p++) begin
         want = (p == 0) ? HDR_SYNC1 : (p == 1) ? HDR_SYNC2 : HDR_CLASS;
         if ($urandom_range(0, 7) == 0) begin
            junk = 8'($urandom_range(0, 255));
            if (junk == want) junk = ~junk;
            send_request(OP_BYTE, junk);
         end
         maybe_tick();
         send_request(OP_BYTE, want);
      end
   endtask

   task send_frame(logic [BYTE_W-1:0] mid, logic [BYTE_W-1:0] cls, logic [BYTE_W-1:0] id,
                   bit corrupt);
      logic [4:0][BYTE_W-1:0] body;
      logic [15:0]            ck;
      body[0] = mid;
      body[1] = 8'($urandom_range(0, 255));
      body[2] = 8'($urandom_range(0, 255));
      body[3] = cls;
      body[4] = id;
      ck = sb.frame_sum(body);
      if (corrupt) ck = ck ^ 16'($urandom_range(1, 65535));
      send_header();
      for (int k = 0; k < 5; k++) begin
         maybe_tick();
         send_request(OP_BYTE, body[k]);
      end
      maybe_tick();
      send_request(OP_BYTE, ck[15:8]);
      maybe_tick();
      send_request(OP_BYTE, ck[7:0]);
   endtask

   task run_sequence();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      send_request(OP_START, 8'($urandom_range(0, 255)));
      if (kind < 45) begin
         send_frame(8'($urandom_range(1, 255)), sb.exp_class, sb.exp_msg_id, 0);
      end else if (kind < 60) begin
         send_frame(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 0);
      end else if (kind < 70) begin
         send_frame(8'($urandom_range(1, 255)), sb.exp_class, sb.exp_msg_id, 1);
      end else if (kind < 80) begin
         send_header();
         send_request(OP_BYTE, NAK_ID);
         n = $urandom_range(0, 3);
         repeat (n) send_request(OP_BYTE, 8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
         n = $urandom_range(1, 30);
         repeat (n) send_request(OP_TICK, 8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
         // Partial frame; the next start request abandons it.
         send_header();
         n = $urandom_range(0, 5);
         repeat (n) send_request(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
   endtask

   task run_random(int count);
      int target;
      target = n_sent + count;
      while (n_sent < target) run_sequence();
   endtask

   // Holds requests back until every owed verdict has arrived and the pipeline is empty.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task configure(logic [BYTE_W-1:0] cls, logic [BYTE_W-1:0] id, logic [TICK_W-1:0] limit);
      logic [1:0]        idx;
      logic [TICK_W-1:0] val;
      drain();
      for (int i = 0; i < 3; i++) begin
         idx = (i == 0) ? CSR_EXP_CLASS : (i == 1) ? CSR_EXP_MSG_ID : CSR_TIMEOUT;
         val = (i == 0) ? TICK_W'(cls) : (i == 1) ? TICK_W'(id) : limit;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= val;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx, val);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Requests while idle are ignored.
      send_request(OP_BYTE, HDR_SYNC1);
      send_request(OP_TICK, 8'h00);
      send_request(OP_UNUSED, 8'hFF);
      // Clean acknowledge against the reset register values.
      send_request(OP_START, 8'h00);
      send_frame(8'h01, 8'h00, 8'h00, 0);
      // NAK message id ends the wait right after the fourth frame byte.
      send_request(OP_START, 8'hFF);
      send_request(OP_BYTE, HDR_SYNC1);
      send_request(OP_BYTE, HDR_SYNC2);
      send_request(OP_BYTE, HDR_CLASS);
      send_request(OP_BYTE, NAK_ID);
      // Timeout limit of one tick; the unused op code is ignored while waiting.
      configure(8'hFF, 8'hFF, 16'd1);
      send_request(OP_START, 8'h5A);
      send_request(OP_UNUSED, 8'hA5);
      send_request(OP_TICK, 8'hFF);
      send_request(OP_TICK, 8'h00);

      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(1, 25)));
      run_random(ITEMS_PER_PHASE);

      // A zero limit times out on the first tick.
      configure(8'h00, 8'h00, 16'd0);
      run_random(ITEMS_PER_PHASE);

      // With the largest limit a run of ticks does not time out.
      configure(8'hFF, 8'hFF, TICK_MAX);
      req_gaps = 0;
      rsp_gaps = 0;
      send_request(OP_START, 8'h00);
      repeat (40) send_request(OP_TICK, 8'($urandom_range(0, 255)));
      send_frame(8'h01, 8'hFF, 8'hFF, 0);
      req_gaps = 1;
      rsp_gaps = 1;
      run_random(ITEMS_PER_PHASE);

      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), TIMEOUT_RESET);
      run_random(ITEMS_PER_PHASE);

      configure(HDR_CLASS, 8'h01, 16'($urandom_range(2, 60)));
      run_random(ITEMS_PER_PHASE);

      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(1, 12)));
      req_gaps = 0;
      rsp_gaps = 0;
      run_random(ITEMS_PER_PHASE);

      drain();
      if (sb.errors == 0)
         $display("ubx_ack_receiver test passed");
      else
         $display("ubx_ack_receiver test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("ubx_ack_receiver test failed");
      $finish;
   end

endmodule
